// File: hw/rtl/wdm_pkg.sv
`default_nettype none

package wdm_pkg;

	// fixed-point setup
	localparam int FADE_STEPS     = 512;
	localparam int GAIN_FRAC_BITS = 16;
	localparam int GAIN_MAX       = 4095;
	localparam int MIX_SHIFT      = 12;
	localparam int FADE_SHIFT     = 9;
	localparam int MAX_LOG2       = 12;

	localparam int CFG_W   = 4;
	localparam int GAIN_W  = 12;
	localparam int SMP_W   = 16;
	localparam int PEAK_W  = 15;
	localparam int FADE_W  = $clog2(FADE_STEPS + 1);
	localparam int ACC_W   = GAIN_W + GAIN_FRAC_BITS;
	localparam int SLOPE_W = ACC_W + 1;
	localparam int MA_W    = SMP_W + 1;
	localparam int MB_W    = (FADE_W + 1 > GAIN_W + 1) ? FADE_W + 1 : GAIN_W + 1;
	localparam int PROD_W  = MA_W + MB_W;

	localparam int IN_W  = 88;
	localparam int OUT_W = 96;

	localparam logic [CFG_W-1:0] LOG2_RESET = 4'd6;

	// mute phase codes, as reported on mute_status
	typedef enum logic [1:0] {
		PH_PASS     = 2'd0,
		PH_FADE_OUT = 2'd1,
		PH_MUTED    = 2'd2,
		PH_FADE_IN  = 2'd3
	} mute_phase_t;

	// mute request codes
	localparam logic [1:0] REQ_MUTE   = 2'd1;
	localparam logic [1:0] REQ_UNMUTE = 2'd2;

	// meter index, also bit of clear_peaks
	localparam int PK_IN_L  = 0;
	localparam int PK_IN_R  = 1;
	localparam int PK_OUT_L = 2;
	localparam int PK_OUT_R = 3;

	// datapath commands, one per cycle
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_PREP,
		OP_GAIN,
		OP_MUL_WL,
		OP_MUL_DL,
		OP_MUL_WR,
		OP_MUL_DR,
		OP_MIX_R,
		OP_FADE_R,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic [4:0]        fill;
		logic [3:0]        clear_peaks;
		logic [1:0]        mute_request;
		logic [11:0]       mix_target;
		logic              block_start;
		logic signed [15:0] wet_right;
		logic signed [15:0] wet_left;
		logic signed [15:0] dry_right;
		logic signed [15:0] dry_left;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         fill;
		logic [1:0]         mute_status;
		logic [14:0]        peak_out_right;
		logic [14:0]        peak_out_left;
		logic [14:0]        peak_in_right;
		logic [14:0]        peak_in_left;
		logic signed [15:0] out_right;
		logic signed [15:0] out_left;
	} out_item_t;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	// magnitude, -32768 saturates to 32767
	function automatic logic [14:0] mag15(input logic signed [15:0] s);
		logic [15:0] n;
		logic [14:0] r;
		n = 16'(-s);
		if (s == 16'sh8000) begin
			r = 15'h7fff;
		end else if (s[15]) begin
			r = n[14:0];
		end else begin
			r = s[14:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wdm_ctrl.sv
`default_nettype none

module wdm_ctrl import wdm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_acc,
	input  wire logic out_full,
	output logic      s_ready,
	output dp_op_t    op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_GAIN,
		S_MWL,
		S_MDL,
		S_MWR,
		S_MDR,
		S_MIXR,
		S_FADER,
		S_FINISH
	} state_t;

	state_t state_q;
	dp_op_t op_q;
	logic   rdy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_IDLE;
			rdy_q   <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_PREP;
						op_q    <= OP_PREP;
						rdy_q   <= 1'b0;
					end
				end
				S_PREP: begin
					state_q <= S_GAIN;
					op_q    <= OP_GAIN;
				end
				S_GAIN: begin
					state_q <= S_MWL;
					op_q    <= OP_MUL_WL;
				end
				S_MWL: begin
					state_q <= S_MDL;
					op_q    <= OP_MUL_DL;
				end
				S_MDL: begin
					state_q <= S_MWR;
					op_q    <= OP_MUL_WR;
				end
				S_MWR: begin
					state_q <= S_MDR;
					op_q    <= OP_MUL_DR;
				end
				S_MDR: begin
					state_q <= S_MIXR;
					op_q    <= OP_MIX_R;
				end
				S_MIXR: begin
					state_q <= S_FADER;
					op_q    <= OP_FADE_R;
				end
				S_FADER: begin
					state_q <= S_FINISH;
					op_q    <= OP_FINISH;
				end
				S_FINISH: begin
					// hold until the output register can take the result
					if (!out_full) begin
						state_q <= S_IDLE;
						op_q    <= OP_IDLE;
						rdy_q   <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					op_q    <= OP_IDLE;
					rdy_q   <= 1'b1;
				end
			endcase
		end
	end

	assign s_ready = rdy_q;
	assign op      = op_q;

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> (op_q == OP_IDLE))
		else $error("ready while a frame is in work");

	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (op_q == OP_PREP) && !rdy_q)
		else $error("accepted frame did not start");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		(op_q == OP_FINISH) && !out_full |=> rdy_q)
		else $error("finished frame did not release input");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/wdm_datapath.sv
`default_nettype none

module wdm_datapath import wdm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             in_acc,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire dp_op_t           op,
	input  wire logic             m_tready,
	output logic                  m_tvalid,
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  out_full
);

	localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(GAIN_MAX) << GAIN_FRAC_BITS;

	// control and state
	logic [CFG_W-1:0]          log2_q;
	mute_phase_t               phase_q;
	logic [FADE_W-1:0]         fade_q;
	logic [ACC_W-1:0]          acc_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic [GAIN_W-1:0]         prev_q;
	logic [PEAK_W-1:0]         peak_q [4];
	logic                      m_tvalid_q;

	// payload
	in_item_t                  in_q;
	logic [GAIN_W-1:0]         g_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [PROD_W-1:0]  sum_q;
	logic signed [SMP_W-1:0]   mixl_q;
	logic signed [SMP_W-1:0]   mixr_q;
	logic signed [SMP_W-1:0]   ol_q;
	logic [OUT_W-1:0]          m_tdata_q;

	logic [CFG_W-1:0]          lsh;
	logic signed [GAIN_W:0]    diff;
	logic signed [SLOPE_W-1:0] slope_new;
	logic signed [ACC_W+1:0]   acc_sum;
	logic [ACC_W-1:0]          acc_next;
	logic signed [MA_W-1:0]    ma;
	logic signed [MB_W-1:0]    mb;
	logic signed [PROD_W-1:0]  mul;
	logic signed [PROD_W:0]    mix_sum;
	logic signed [SMP_W-1:0]   mix_sat;
	logic signed [SMP_W-1:0]   fade_sat;
	logic signed [SMP_W-1:0]   or_val;
	logic [PEAK_W-1:0]         pk_ol;
	logic [PEAK_W-1:0]         pk_or;
	logic [PEAK_W-1:0]         mag_ol;
	logic [PEAK_W-1:0]         mag_or;
	logic [PEAK_W-1:0]         mag_dl;
	logic [PEAK_W-1:0]         mag_dr;
	mute_phase_t               phase_next;
	logic [FADE_W-1:0]         fade_next;
	logic [FADE_W-1:0]         fade_dec;
	logic [FADE_W-1:0]         fade_inc;
	logic                      fin;
	out_item_t                 res;

	// gain slope: (target - previous) scaled, arithmetic shift by log2 of block length
	assign lsh       = (log2_q > CFG_W'(MAX_LOG2)) ? CFG_W'(MAX_LOG2) : log2_q;
	assign diff      = $signed({1'b0, in_q.mix_target}) - $signed({1'b0, prev_q});
	assign slope_new = $signed({diff, {GAIN_FRAC_BITS{1'b0}}}) >>> lsh;

	// accumulator step with clamp to the gain range
	assign acc_sum = $signed({2'b00, acc_q}) + $signed({slope_q[SLOPE_W-1], slope_q});
	always_comb begin
		if (acc_sum < 0) begin
			acc_next = '0;
		end else if (acc_sum > $signed({2'b00, ACC_MAX})) begin
			acc_next = ACC_MAX;
		end else begin
			acc_next = acc_sum[ACC_W-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (op)
			OP_MUL_WL: begin
				ma = MA_W'(in_q.wet_left);
				mb = MB_W'(g_q);
			end
			OP_MUL_DL: begin
				ma = MA_W'(in_q.dry_left);
				mb = MB_W'(GAIN_W'(GAIN_MAX) - g_q);
			end
			OP_MUL_WR: begin
				ma = MA_W'(in_q.wet_right);
				mb = MB_W'(g_q);
			end
			OP_MUL_DR: begin
				ma = MA_W'(in_q.dry_right);
				mb = MB_W'(GAIN_W'(GAIN_MAX) - g_q);
			end
			OP_MIX_R: begin
				ma = MA_W'(mixl_q);
				mb = MB_W'(fade_q);
			end
			OP_FADE_R: begin
				ma = MA_W'(mixr_q);
				mb = MB_W'(fade_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign mul      = ma * mb;
	assign mix_sum  = $signed({sum_q[PROD_W-1], sum_q}) + $signed({prod_q[PROD_W-1], prod_q});
	assign mix_sat  = sat16(32'(mix_sum >>> MIX_SHIFT));
	assign fade_sat = sat16(32'(prod_q >>> FADE_SHIFT));

	always_comb begin
		case (phase_q)
			PH_PASS:  or_val = mixr_q;
			PH_MUTED: or_val = '0;
			default:  or_val = fade_sat;
		endcase
	end

	assign mag_dl = mag15(in_q.dry_left);
	assign mag_dr = mag15(in_q.dry_right);
	assign mag_ol = mag15(ol_q);
	assign mag_or = mag15(or_val);
	assign pk_ol  = (mag_ol > peak_q[PK_OUT_L]) ? mag_ol : peak_q[PK_OUT_L];
	assign pk_or  = (mag_or > peak_q[PK_OUT_R]) ? mag_or : peak_q[PK_OUT_R];

	// fade count advance after the frame
	assign fade_dec = (fade_q != '0) ? fade_q - 1'b1 : fade_q;
	assign fade_inc = fade_q + 1'b1;
	always_comb begin
		phase_next = phase_q;
		fade_next  = fade_q;
		case (phase_q)
			PH_FADE_OUT: begin
				fade_next = fade_dec;
				if (fade_dec == '0) begin
					phase_next = PH_MUTED;
				end
			end
			PH_FADE_IN: begin
				fade_next = fade_inc;
				if (fade_inc >= FADE_W'(FADE_STEPS)) begin
					phase_next = PH_PASS;
					fade_next  = '0;
				end
			end
			default: begin
				phase_next = phase_q;
				fade_next  = fade_q;
			end
		endcase
	end

	assign fin = (op == OP_FINISH) && !out_full;

	always_comb begin
		res                = '0;
		res.out_left       = ol_q;
		res.out_right      = or_val;
		res.peak_in_left   = peak_q[PK_IN_L];
		res.peak_in_right  = peak_q[PK_IN_R];
		res.peak_out_left  = pk_ol;
		res.peak_out_right = pk_or;
		res.mute_status    = phase_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_q     <= LOG2_RESET;
			phase_q    <= PH_MUTED;
			fade_q     <= '0;
			acc_q      <= '0;
			slope_q    <= '0;
			prev_q     <= '0;
			peak_q     <= '{default: '0};
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				log2_q <= cfg_wdata;
			end
			if (fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (op)
				OP_PREP: begin
					// mute request acts before the frame is scaled
					if (phase_q == PH_PASS && in_q.mute_request == REQ_MUTE) begin
						phase_q <= PH_FADE_OUT;
						fade_q  <= FADE_W'(FADE_STEPS);
					end else if (phase_q == PH_MUTED && in_q.mute_request == REQ_UNMUTE) begin
						phase_q <= PH_FADE_IN;
						fade_q  <= '0;
					end
					if (mag_dl > peak_q[PK_IN_L]) begin
						peak_q[PK_IN_L] <= mag_dl;
					end
					if (mag_dr > peak_q[PK_IN_R]) begin
						peak_q[PK_IN_R] <= mag_dr;
					end
					if (in_q.block_start) begin
						acc_q   <= {prev_q, {GAIN_FRAC_BITS{1'b0}}};
						slope_q <= slope_new;
						prev_q  <= in_q.mix_target;
					end
				end
				OP_GAIN: begin
					acc_q <= acc_next;
				end
				OP_FINISH: begin
					if (fin) begin
						phase_q    <= phase_next;
						fade_q     <= fade_next;
						peak_q[PK_IN_L]  <= in_q.clear_peaks[PK_IN_L]  ? '0 : peak_q[PK_IN_L];
						peak_q[PK_IN_R]  <= in_q.clear_peaks[PK_IN_R]  ? '0 : peak_q[PK_IN_R];
						peak_q[PK_OUT_L] <= in_q.clear_peaks[PK_OUT_L] ? '0 : pk_ol;
						peak_q[PK_OUT_R] <= in_q.clear_peaks[PK_OUT_R] ? '0 : pk_or;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_q <= in_item_t'(s_tdata);
		end
		case (op)
			OP_GAIN: begin
				g_q <= acc_q[ACC_W-1:GAIN_FRAC_BITS];
			end
			OP_MUL_WL: begin
				prod_q <= mul;
			end
			OP_MUL_DL: begin
				prod_q <= mul;
				sum_q  <= prod_q;
			end
			OP_MUL_WR: begin
				prod_q <= mul;
				mixl_q <= mix_sat;
			end
			OP_MUL_DR: begin
				prod_q <= mul;
				sum_q  <= prod_q;
			end
			OP_MIX_R: begin
				prod_q <= mul;
				mixr_q <= mix_sat;
			end
			OP_FADE_R: begin
				prod_q <= mul;
				case (phase_q)
					PH_PASS:  ol_q <= mixl_q;
					PH_MUTED: ol_q <= '0;
					default:  ol_q <= fade_sat;
				endcase
			end
			OP_FINISH: begin
				if (fin) begin
					m_tdata_q <= res;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_full = m_tvalid_q && !m_tready;

endmodule

`default_nettype wire

// File: hw/rtl/wet_dry_mixer_mute_fade.sv
`default_nettype none

// Wet/dry stereo crossfade mixer with mute ramp and peak meters. Each request on the
// input stream is one frame; the block returns exactly one result frame for it. Both
// channels are mixed as (wet*g + dry*(4095-g))>>12 and saturated, where the wet gain
// g slides linearly from the previous target to mix_target over 2^log2_block_frames
// frames after each block_start frame. The mute machine comes out of reset muted:
// send mute_request 2 to fade in over 512 frames, 1 to fade out. Peak meters of the
// dry inputs and of the outputs are reported with every frame and cleared per
// clear_peaks bit after the report. A frame is accepted while idle and then steps
// through prep, gain, the four mix products, the two fade products and finish, which
// holds until the output is drained; the single shared 17x13 multiplier does those
// products one after the other. A finished result waits in the output register
// while the next frame is taken in. Write log2_block_frames only while idle.
module wet_dry_mixer_mute_fade import wdm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// log2_block_frames
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// from bit 0: dry_left 16, dry_right 16, wet_left 16, wet_right 16,
	// block_start 1, mix_target 12, mute_request 2, clear_peaks 4, zero fill 5
	input  wire logic [IN_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// from bit 0: out_left 16, out_right 16, peak_in_left 15, peak_in_right 15,
	// peak_out_left 15, peak_out_right 15, mute_status 2, zero fill 2
	output logic [OUT_W-1:0]      m_tdata
);

	logic   in_acc;
	logic   out_full;
	dp_op_t op;

	// a frame is taken when the sequencer is idle
	assign in_acc = s_tvalid && s_tready;

	// sequencer: steps the datapath through one frame
	wdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_acc   (in_acc),
		.out_full (out_full),
		.s_ready  (s_tready),
		.op       (op)
	);

	// gain ramp, shared multiplier, mute scaling, meters and output register
	wdm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_acc    (in_acc),
		.s_tdata   (s_tdata),
		.op        (op),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.out_full  (out_full)
	);

endmodule

`default_nettype wire
